// ===== design/four_wheel_current_limiter_core_macros.svh =====
// Assertion macros for the four-wheel current limiter checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef FOUR_WHEEL_CURRENT_LIMITER_CORE_MACROS_SVH
`define FOUR_WHEEL_CURRENT_LIMITER_CORE_MACROS_SVH

// Clocked assertion, quiet while reset is asserted
`define FWCL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define FWCL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/fwcl_pkg.sv =====
// Shared types and constants of the four-wheel current limiter.
// No dependencies; imported by the controller, datapath and top level.
package fwcl_pkg;

    localparam int NUM_WHEELS = 4;
    localparam int CMD_W      = 16;
    localparam int TOTAL_W    = 17;
    localparam int WHEEL_W    = 15;
    localparam int POWER_W    = 8;
    localparam int SUM_W      = 18;
    localparam int PROD_W     = TOTAL_W + WHEEL_W;
    localparam int QUO_W      = WHEEL_W;
    localparam int IDX_W      = 2;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Power buffer thresholds of the tier rules
    localparam logic [POWER_W-1:0] PWR_LOWER_LO = 8'd10;
    localparam logic [POWER_W-1:0] PWR_LOWER_HI = 8'd40;
    localparam logic [POWER_W-1:0] PWR_BOTTOM   = 8'd15;
    localparam logic [POWER_W-1:0] PWR_ZERO     = 8'd7;

    // Fixed limits used while the referee link is lost
    localparam logic [TOTAL_W-1:0] FIXED_TOTAL = 17'd13000;
    localparam logic [WHEEL_W-1:0] FIXED_WHEEL = 15'd4500;

    // Register reset values
    localparam logic [TOTAL_W-1:0] RST_TOTAL_NORMAL = 17'd13000;
    localparam logic [WHEEL_W-1:0] RST_WHEEL_NORMAL = 15'd4500;
    localparam logic [TOTAL_W-1:0] RST_TOTAL_LOWER  = 17'd10000;
    localparam logic [WHEEL_W-1:0] RST_WHEEL_LOWER  = 15'd3500;
    localparam logic [TOTAL_W-1:0] RST_TOTAL_BOTTOM = 17'd6000;
    localparam logic [WHEEL_W-1:0] RST_WHEEL_BOTTOM = 15'd2000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_NORMAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_NORMAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LOWER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_LOWER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BOTTOM = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_BOTTOM = 3'd5;

    // Last divider step of one wheel
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);
    localparam logic [IDX_W-1:0]  LAST_WHEEL = IDX_W'(NUM_WHEELS - 1);

    typedef enum logic [2:0] {
        TIER_NORMAL = 3'd0,
        TIER_LOWER  = 3'd1,
        TIER_BOTTOM = 3'd2,
        TIER_ZERO   = 3'd3,
        TIER_FIXED  = 3'd4
    } tier_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic             load;
        logic             prep;
        logic             mul;
        logic             div_step;
        logic             div_last;
        logic [IDX_W-1:0] wheel_idx;
        logic             out_load;
    } fwcl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scaled;
    } fwcl_status_t;

endpackage

// ===== design/four_wheel_current_limiter_core.sv =====
// Top level of the four-wheel current limiter: controller plus datapath.
// Depends on fwcl_pkg, fwcl_ctrl and fwcl_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) carries four signed wheel commands,
//   the remaining power buffer and the link-lost flag. Output channel
//   (out_valid/out_ready) returns four limited currents and was_scaled.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   the six tier limits; cfg_ready is always high, unknown indexes dropped.
//   Without scaling an item passes the prepare, multiply and finish
//   states into the output register; with scaling the divide steps of
//   every wheel come between. Scaling takes four passes of one shared
//   multiplier and a 15-step restoring divider, one quotient bit per cycle.
//   Items are taken one at a time; the output register lets the next item
//   start while a result waits. If the receiver stalls, the next result
//   holds in the datapath until the output register is free.
//   Reset: limits return to their defaults, the tier returns to normal and
//   no result is pending.
module four_wheel_current_limiter_core
    import fwcl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [CMD_W-1:0] front_left_cmd,
    input  logic signed [CMD_W-1:0] front_right_cmd,
    input  logic signed [CMD_W-1:0] back_left_cmd,
    input  logic signed [CMD_W-1:0] back_right_cmd,
    input  logic [POWER_W-1:0]      remain_power,
    input  logic                    link_lost,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [CMD_W-1:0] front_left_out,
    output logic signed [CMD_W-1:0] front_right_out,
    output logic signed [CMD_W-1:0] back_left_out,
    output logic signed [CMD_W-1:0] back_right_out,
    output logic                    was_scaled,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    fwcl_cmd_t    cmd;
    fwcl_status_t status;

    // Accept a configuration transfer in every cycle
    assign cfg_ready = 1'b1;

    fwcl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    fwcl_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .front_left_cmd  (front_left_cmd),
        .front_right_cmd (front_right_cmd),
        .back_left_cmd   (back_left_cmd),
        .back_right_cmd  (back_right_cmd),
        .remain_power    (remain_power),
        .link_lost       (link_lost),
        .front_left_out  (front_left_out),
        .front_right_out (front_right_out),
        .back_left_out   (back_left_out),
        .back_right_out  (back_right_out),
        .was_scaled      (was_scaled)
    );

endmodule

// ===== design/fwcl_datapath.sv =====
// Datapath of the four-wheel current limiter: registers, tier update, clamp,
// multiplier and restoring divider. Depends on fwcl_pkg.
module fwcl_datapath
    import fwcl_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  fwcl_cmd_t                    cmd,
    output fwcl_status_t                 status,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic signed [CMD_W-1:0]      front_left_cmd,
    input  logic signed [CMD_W-1:0]      front_right_cmd,
    input  logic signed [CMD_W-1:0]      back_left_cmd,
    input  logic signed [CMD_W-1:0]      back_right_cmd,
    input  logic [POWER_W-1:0]           remain_power,
    input  logic                         link_lost,
    output logic signed [CMD_W-1:0]      front_left_out,
    output logic signed [CMD_W-1:0]      front_right_out,
    output logic signed [CMD_W-1:0]      back_left_out,
    output logic signed [CMD_W-1:0]      back_right_out,
    output logic                         was_scaled
);

    // Configuration registers
    logic [TOTAL_W-1:0] total_normal_reg, total_lower_reg, total_bottom_reg;
    logic [WHEEL_W-1:0] wheel_normal_reg, wheel_lower_reg, wheel_bottom_reg;

    // Item and working registers
    logic signed [CMD_W-1:0] cmd_reg   [NUM_WHEELS];
    logic signed [CMD_W-1:0] clamp_reg [NUM_WHEELS];
    logic [POWER_W-1:0]      power_reg;
    logic                    link_reg;
    tier_t                   tier_reg;
    tier_t                   tier_next;
    logic [SUM_W-1:0]        sum_reg;
    logic [TOTAL_W-1:0]      total_reg;
    logic                    scaled_reg;
    logic [SUM_W-1:0]        rem_reg;
    logic [QUO_W-1:0]        low_reg;
    logic                    neg_reg;

    // Output registers
    logic signed [CMD_W-1:0] out_reg [NUM_WHEELS];
    logic                    scaled_out_reg;

    // Combinational signals
    logic [TOTAL_W-1:0]        total_w;
    logic [WHEEL_W-1:0]        wheel_w;
    logic signed [CMD_W:0]     ext_w   [NUM_WHEELS];
    logic signed [CMD_W:0]     neg_w   [NUM_WHEELS];
    logic [CMD_W:0]            abs_w   [NUM_WHEELS];
    logic signed [CMD_W-1:0]   clamp_w [NUM_WHEELS];
    logic signed [CMD_W:0]     lim_w;
    logic signed [CMD_W:0]     nlim_w;
    logic [SUM_W-1:0]          sum_w;
    logic signed [CMD_W-1:0]   sel_w;
    logic signed [CMD_W-1:0]   sel_neg_w;
    logic [WHEEL_W-1:0]        mag_w;
    logic [PROD_W-1:0]         prod_w;
    logic [SUM_W:0]            trial_w;
    logic [SUM_W:0]            diff_w;
    logic                      ge_w;
    logic [QUO_W-1:0]          quo_w;
    logic signed [CMD_W-1:0]   quo_s_w;

    // Update the sticky tier, last matching rule wins
    always_comb
    begin
        tier_next = tier_reg;
        if ((power_reg > PWR_LOWER_LO) && (power_reg < PWR_LOWER_HI))
        begin
            tier_next = TIER_LOWER;
        end
        if (power_reg < PWR_BOTTOM)
        begin
            tier_next = TIER_BOTTOM;
        end
        if (power_reg < PWR_ZERO)
        begin
            tier_next = TIER_ZERO;
        end
        if (link_reg)
        begin
            tier_next = TIER_FIXED;
        end
    end

    // Select the limits of the new tier; unused codes act as normal
    always_comb
    begin
        case (tier_next)
            TIER_LOWER:
            begin
                total_w = total_lower_reg;
                wheel_w = wheel_lower_reg;
            end
            TIER_BOTTOM:
            begin
                total_w = total_bottom_reg;
                wheel_w = wheel_bottom_reg;
            end
            TIER_ZERO:
            begin
                total_w = '0;
                wheel_w = '0;
            end
            TIER_FIXED:
            begin
                total_w = FIXED_TOTAL;
                wheel_w = FIXED_WHEEL;
            end
            default:
            begin
                total_w = total_normal_reg;
                wheel_w = wheel_normal_reg;
            end
        endcase
    end

    // Take magnitudes, sum them and clamp each command
    always_comb
    begin
        lim_w  = $signed({2'b00, wheel_w});
        nlim_w = -lim_w;
        sum_w  = '0;
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            ext_w[i] = {cmd_reg[i][CMD_W-1], cmd_reg[i]};
            neg_w[i] = -ext_w[i];
            abs_w[i] = ext_w[i][CMD_W] ? $unsigned(neg_w[i]) : $unsigned(ext_w[i]);
            sum_w    = sum_w + SUM_W'(abs_w[i]);
            if (ext_w[i] > lim_w)
            begin
                clamp_w[i] = lim_w[CMD_W-1:0];
            end
            else if (ext_w[i] < nlim_w)
            begin
                clamp_w[i] = nlim_w[CMD_W-1:0];
            end
            else
            begin
                clamp_w[i] = cmd_reg[i];
            end
        end
    end

    // Form total times magnitude of the selected wheel
    always_comb
    begin
        sel_w     = clamp_reg[cmd.wheel_idx];
        sel_neg_w = -sel_w;
        mag_w     = sel_w[CMD_W-1] ? sel_neg_w[WHEEL_W-1:0] : sel_w[WHEEL_W-1:0];
        prod_w    = PROD_W'(total_reg) * PROD_W'(mag_w);
    end

    // One restoring divider step
    always_comb
    begin
        trial_w = {rem_reg, low_reg[QUO_W-1]};
        diff_w  = trial_w - {1'b0, sum_reg};
        ge_w    = (trial_w >= {1'b0, sum_reg});
        quo_w   = {low_reg[QUO_W-2:0], ge_w};
        quo_s_w = neg_reg ? -$signed({1'b0, quo_w}) : $signed({1'b0, quo_w});
    end

    assign status.scaled = scaled_reg;

    // Write configuration registers; other indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_normal_reg <= RST_TOTAL_NORMAL;
            wheel_normal_reg <= RST_WHEEL_NORMAL;
            total_lower_reg  <= RST_TOTAL_LOWER;
            wheel_lower_reg  <= RST_WHEEL_LOWER;
            total_bottom_reg <= RST_TOTAL_BOTTOM;
            wheel_bottom_reg <= RST_WHEEL_BOTTOM;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TOTAL_NORMAL: total_normal_reg <= cfg_data[TOTAL_W-1:0];
                CFG_WHEEL_NORMAL: wheel_normal_reg <= cfg_data[WHEEL_W-1:0];
                CFG_TOTAL_LOWER:  total_lower_reg  <= cfg_data[TOTAL_W-1:0];
                CFG_WHEEL_LOWER:  wheel_lower_reg  <= cfg_data[WHEEL_W-1:0];
                CFG_TOTAL_BOTTOM: total_bottom_reg <= cfg_data[TOTAL_W-1:0];
                CFG_WHEEL_BOTTOM: wheel_bottom_reg <= cfg_data[WHEEL_W-1:0];
                default:          ;
            endcase
        end
    end

    // Hold the sticky tier
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tier_reg <= TIER_NORMAL;
        end
        else if (cmd.prep)
        begin
            tier_reg <= tier_next;
        end
    end

    // Capture the item, prepare limits, run multiply and divide steps
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg[0] <= front_left_cmd;
            cmd_reg[1] <= front_right_cmd;
            cmd_reg[2] <= back_left_cmd;
            cmd_reg[3] <= back_right_cmd;
            power_reg  <= remain_power;
            link_reg   <= link_lost;
        end
        if (cmd.prep)
        begin
            for (int i = 0; i < NUM_WHEELS; i++)
            begin
                clamp_reg[i] <= clamp_w[i];
            end
            sum_reg    <= sum_w;
            total_reg  <= total_w;
            scaled_reg <= (sum_w > SUM_W'(total_w));
        end
        if (cmd.mul)
        begin
            rem_reg <= SUM_W'(prod_w[PROD_W-1:QUO_W]);
            low_reg <= prod_w[QUO_W-1:0];
            neg_reg <= sel_w[CMD_W-1];
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge_w ? diff_w[SUM_W-1:0] : trial_w[SUM_W-1:0];
            low_reg <= quo_w;
        end
        if (cmd.div_last)
        begin
            clamp_reg[cmd.wheel_idx] <= quo_s_w;
        end
        if (cmd.out_load)
        begin
            for (int i = 0; i < NUM_WHEELS; i++)
            begin
                out_reg[i] <= clamp_reg[i];
            end
            scaled_out_reg <= scaled_reg;
        end
    end

    assign front_left_out  = out_reg[0];
    assign front_right_out = out_reg[1];
    assign back_left_out   = out_reg[2];
    assign back_right_out  = out_reg[3];
    assign was_scaled      = scaled_out_reg;

endmodule

// ===== design/fwcl_ctrl.sv =====
// Controller of the four-wheel current limiter: sequences prepare, multiply
// and divide steps per wheel and owns the handshakes. Depends on fwcl_pkg.
module fwcl_ctrl
    import fwcl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  fwcl_status_t status,
    output fwcl_cmd_t    cmd
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0]  wheel_reg, wheel_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = status.scaled ? ST_DIV : ST_FINISH;
            end
            ST_DIV:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = (wheel_reg == LAST_WHEEL) ? ST_FINISH : ST_MUL;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands and handshake outputs
    always_comb
    begin
        cmd           = '0;
        cmd.wheel_idx = wheel_reg;
        in_ready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            ST_MUL:
            begin
                cmd.mul = status.scaled;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.div_last = (step_reg == LAST_STEP);
            end
            ST_FINISH:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Advance step and wheel counters, track the output register
    always_comb
    begin
        step_next  = step_reg;
        wheel_next = wheel_reg;
        if (cmd.prep)
        begin
            step_next  = '0;
            wheel_next = '0;
        end
        else if (cmd.div_step)
        begin
            if (cmd.div_last)
            begin
                step_next  = '0;
                wheel_next = wheel_reg + 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            wheel_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            wheel_reg     <= wheel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/fwcl_checker.sv =====
// Port-level checker of the four-wheel current limiter and its bind.
// Depends on fwcl_pkg and four_wheel_current_limiter_core_macros.svh.
`include "four_wheel_current_limiter_core_macros.svh"

module fwcl_checker
    import fwcl_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [CMD_W-1:0] front_left_out,
    input logic signed [CMD_W-1:0] front_right_out,
    input logic signed [CMD_W-1:0] back_left_out,
    input logic signed [CMD_W-1:0] back_right_out,
    input logic                    was_scaled
);

    // A stalled result holds until its transfer
    `FWCL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(front_left_out) && $stable(front_right_out) && $stable(back_left_out) && $stable(back_right_out) && $stable(was_scaled), "stalled result changed")

    // One item at a time: busy right after an input transfer
    `FWCL_ASSERT(a_busy_after_in, in_valid && in_ready |=> !in_ready, "input taken while busy")

    // Clamp and scaling never yield the most negative code
    `FWCL_ASSERT(a_no_min_code, out_valid |-> front_left_out != -16'sd32768 && front_right_out != -16'sd32768 && back_left_out != -16'sd32768 && back_right_out != -16'sd32768, "limited current out of range")

    // No result is pending during reset
    `FWCL_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid, "result valid in reset")

endmodule

bind four_wheel_current_limiter_core fwcl_checker u_fwcl_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .front_left_out  (front_left_out),
    .front_right_out (front_right_out),
    .back_left_out   (back_left_out),
    .back_right_out  (back_right_out),
    .was_scaled      (was_scaled)
);
